@@ rtl/core/scl2x_pkg.sv @@
// ----------------------------------------------------------------------------
// scl2x_pkg
// Shared types and constants for the 2x pixel-art upscaler.
// ----------------------------------------------------------------------------
package scl2x_pkg;

    // default geometry and pixel size
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int PIXEL_BITS_DEF = 16;

    // configuration register
    localparam int CFG_BITS        = 9;
    localparam int CFG_WIDTH_RESET = 256;
    localparam int MIN_WIDTH       = 2;

    // result coordinate fields
    localparam int ROW_BITS     = 12;
    localparam int COL_OUT_BITS = 8;
    localparam logic [ROW_BITS-1:0] ROW_MAX = 12'd4095;

    // input item kinds
    typedef enum logic [0:0] {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } t_action;

    // per-item control carried from the sequencer to the kernel stage
    typedef struct packed {
        logic emit;     // row above exists, a block is produced
        logic has_b;    // up neighbor inside the frame
        logic has_d;    // left neighbor inside the frame
        logic has_f;    // right neighbor inside the frame
    } t_s1_ctrl;

endpackage

@@ rtl/core/scl2x_ram.sv @@
// ----------------------------------------------------------------------------
// scl2x_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scl2x_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/scl2x_ctrl.sv @@
// ----------------------------------------------------------------------------
// scl2x_ctrl
// Column and row sequencer: width register, line store addressing and the
// control word of the item in the kernel stage.
// ----------------------------------------------------------------------------
module scl2x_ctrl import scl2x_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_BITS-1:0]          i_cfg_wr_data,
    input  logic                         i_valid,
    input  logic                         i_action,
    output logic                         o_ready,
    input  logic                         i_s1_advance,
    output logic                         o_load,
    output logic [$clog2(MAX_WIDTH)-1:0] o_col,
    output logic [$clog2(MAX_WIDTH)-1:0] o_prev_rd_addr,
    output logic                         o_s1_valid,
    output t_s1_ctrl                     o_s1_ctrl,
    output logic [$clog2(MAX_WIDTH)-1:0] o_s1_col,
    output logic [ROW_BITS-1:0]          o_s1_row
);

    localparam int ColW = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CmpW = (WW > CFG_BITS) ? WW : CFG_BITS;
    localparam logic [WW-1:0] WidthReset =
        (CFG_WIDTH_RESET > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(CFG_WIDTH_RESET);

    logic [WW-1:0]       r_width;
    logic [WW-1:0]       n_width;
    logic [ColW-1:0]     r_col;
    logic [ColW-1:0]     n_col;
    logic [ROW_BITS-1:0] r_row;
    logic [ROW_BITS-1:0] n_row;
    logic                r_s1_valid;
    t_s1_ctrl            r_s1_ctrl;
    t_s1_ctrl            n_s1_ctrl;
    logic [ColW-1:0]     r_s1_col;
    logic [ROW_BITS-1:0] r_s1_row;

    logic [CmpW-1:0] cfg_ext;
    logic [WW-1:0]   col_inc;
    logic            last_col;
    logic            flush;
    logic            accept;

    // clamp the written width into the supported range
    always_comb begin
        cfg_ext = CmpW'(i_cfg_wr_data);
        if (cfg_ext < CmpW'(MIN_WIDTH)) begin
            n_width = WW'(MIN_WIDTH);
        end else if (cfg_ext > CmpW'(MAX_WIDTH)) begin
            n_width = WW'(MAX_WIDTH);
        end else begin
            n_width = WW'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WidthReset;
        end else if (i_cfg_wr_en) begin
            r_width <= n_width;
        end
    end

    // transfer handling: a flush with no row stored is taken and dropped
    assign o_ready  = !r_s1_valid || i_s1_advance;
    assign accept   = i_valid && o_ready;
    assign flush    = (i_action == ACT_FLUSH);
    assign o_load   = accept && !(flush && (r_row == '0));

    // next position
    always_comb begin
        col_inc  = WW'(r_col) + WW'(1);
        last_col = (col_inc >= r_width);
        n_col    = last_col ? '0 : col_inc[ColW-1:0];
        n_row    = r_row;
        if (last_col) begin
            if (flush) begin
                n_row = '0;
            end else if (r_row < ROW_MAX) begin
                n_row = r_row + ROW_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_load) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // control word of the item entering the kernel stage
    always_comb begin
        n_s1_ctrl.emit  = (r_row != '0);
        n_s1_ctrl.has_b = (r_row > ROW_BITS'(1));
        n_s1_ctrl.has_d = (r_col != '0);
        n_s1_ctrl.has_f = !last_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= o_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_s1_ctrl <= n_s1_ctrl;
            r_s1_col  <= r_col;
            r_s1_row  <= r_row - ROW_BITS'(1);
        end
    end

    // prefetch the next centre, which is also this item's right neighbor
    assign o_col          = r_col;
    assign o_prev_rd_addr = n_col;
    assign o_s1_valid     = r_s1_valid;
    assign o_s1_ctrl      = r_s1_ctrl;
    assign o_s1_col       = r_s1_col;
    assign o_s1_row       = r_s1_row;

endmodule

@@ rtl/core/scl2x_kernel.sv @@
// ----------------------------------------------------------------------------
// scl2x_kernel
// Neighborhood registers, the 2x expansion rule and the result register.
// ----------------------------------------------------------------------------
module scl2x_kernel import scl2x_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic                         i_flush,
    input  logic [PIXEL_BITS-1:0]        i_pixel,
    input  logic [PIXEL_BITS-1:0]        i_prev_rd_data,
    input  logic [PIXEL_BITS-1:0]        i_older_rd_data,
    input  logic                         i_s1_valid,
    input  t_s1_ctrl                     i_s1_ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_s1_col,
    input  logic [ROW_BITS-1:0]          i_s1_row,
    output logic                         o_s1_advance,
    output logic [PIXEL_BITS-1:0]        o_centre,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [PIXEL_BITS-1:0]        o_top_left,
    output logic [PIXEL_BITS-1:0]        o_top_right,
    output logic [PIXEL_BITS-1:0]        o_bottom_left,
    output logic [PIXEL_BITS-1:0]        o_bottom_right,
    output logic [COL_OUT_BITS-1:0]      o_src_col,
    output logic [ROW_BITS-1:0]          o_src_row
);

    localparam int ColW = $clog2(MAX_WIDTH);

    logic [PIXEL_BITS-1:0] r_e;
    logic [PIXEL_BITS-1:0] r_d;
    logic [PIXEL_BITS-1:0] r_h;
    logic [PIXEL_BITS-1:0] r_left;

    logic                    r_o_valid;
    logic [PIXEL_BITS-1:0]   r_e0;
    logic [PIXEL_BITS-1:0]   r_e1;
    logic [PIXEL_BITS-1:0]   r_e2;
    logic [PIXEL_BITS-1:0]   r_e3;
    logic [COL_OUT_BITS-1:0] r_src_col;
    logic [ROW_BITS-1:0]     r_src_row;

    logic [PIXEL_BITS-1:0] b;
    logic [PIXEL_BITS-1:0] d;
    logic [PIXEL_BITS-1:0] f;
    logic [PIXEL_BITS-1:0] n_e0;
    logic [PIXEL_BITS-1:0] n_e1;
    logic [PIXEL_BITS-1:0] n_e2;
    logic [PIXEL_BITS-1:0] n_e3;
    logic [ColW+COL_OUT_BITS-1:0] col_ext;
    logic out_free;
    logic s1_emit;

    // capture centre, left and down pixels as the item enters
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_e <= i_prev_rd_data;
            r_d <= r_left;
            r_h <= i_flush ? i_prev_rd_data : i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_prev_rd_data;
        end
    end

    // edge replacement and the expansion rule
    always_comb begin
        b = i_s1_ctrl.has_b ? i_older_rd_data : r_e;
        d = i_s1_ctrl.has_d ? r_d : r_e;
        f = i_s1_ctrl.has_f ? i_prev_rd_data : r_e;
        if ((b != r_h) && (d != f)) begin
            n_e0 = (d == b)   ? d : r_e;
            n_e1 = (b == f)   ? f : r_e;
            n_e2 = (d == r_h) ? d : r_e;
            n_e3 = (r_h == f) ? f : r_e;
        end else begin
            n_e0 = r_e;
            n_e1 = r_e;
            n_e2 = r_e;
            n_e3 = r_e;
        end
    end

    assign col_ext = {{COL_OUT_BITS{1'b0}}, i_s1_col};

    // result register, the stage holds while a result waits
    assign out_free     = !r_o_valid || i_ready;
    assign s1_emit      = i_s1_valid && i_s1_ctrl.emit;
    assign o_s1_advance = !i_s1_ctrl.emit || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_emit) begin
            r_e0      <= n_e0;
            r_e1      <= n_e1;
            r_e2      <= n_e2;
            r_e3      <= n_e3;
            r_src_col <= col_ext[COL_OUT_BITS-1:0];
            r_src_row <= i_s1_row;
        end
    end

    assign o_centre       = r_e;
    assign o_valid        = r_o_valid;
    assign o_top_left     = r_e0;
    assign o_top_right    = r_e1;
    assign o_bottom_left  = r_e2;
    assign o_bottom_right = r_e3;
    assign o_src_col      = r_src_col;
    assign o_src_row      = r_src_row;

endmodule

@@ rtl/core/scale2x_pixel_upscaler.sv @@
// ----------------------------------------------------------------------------
// scale2x_pixel_upscaler
// Streaming 2x pixel-art upscaler with two line stores.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order; the pixel at column x of row y yields
// the 2x2 output block of the pixel at column x of row y-1, so the first row
// gives no result and one row of flush transfers after the last row emits the
// bottom row (a flush with no row stored is taken and dropped). Neighbors
// outside the frame take the centre value. The block takes one transfer per
// clock while results are taken, and stalls while a result waits; a result
// comes from the registered read of the line stores followed by the result
// register. Each line store does one read per transfer; the older one also
// one write, the recent one a write for pixels only. The right neighbor read
// for one pixel is the centre of the next, so no second read port is needed.
// The line stores are not cleared after reset and need no clearing pass.
// Write frame_width only while the block is idle.
// ----------------------------------------------------------------------------
module scale2x_pixel_upscaler import scl2x_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_BITS-1:0]     i_cfg_wr_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_action,
    input  logic [PIXEL_BITS-1:0]   i_pixel,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [PIXEL_BITS-1:0]   o_top_left,
    output logic [PIXEL_BITS-1:0]   o_top_right,
    output logic [PIXEL_BITS-1:0]   o_bottom_left,
    output logic [PIXEL_BITS-1:0]   o_bottom_right,
    output logic [COL_OUT_BITS-1:0] o_src_col,
    output logic [ROW_BITS-1:0]     o_src_row
);

    localparam int ColW = $clog2(MAX_WIDTH);

    logic                  load;
    logic                  flush;
    logic [ColW-1:0]       col;
    logic [ColW-1:0]       prev_rd_addr;
    logic [PIXEL_BITS-1:0] prev_rd_data;
    logic [PIXEL_BITS-1:0] older_rd_data;
    logic [PIXEL_BITS-1:0] centre;
    logic                  s1_valid;
    logic                  s1_advance;
    t_s1_ctrl              s1_ctrl;
    logic [ColW-1:0]       s1_col;
    logic [ROW_BITS-1:0]   s1_row;

    assign flush = (i_action == ACT_FLUSH);

    // position sequencer
    scl2x_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .i_action       (i_action),
        .o_ready        (o_ready),
        .i_s1_advance   (s1_advance),
        .o_load         (load),
        .o_col          (col),
        .o_prev_rd_addr (prev_rd_addr),
        .o_s1_valid     (s1_valid),
        .o_s1_ctrl      (s1_ctrl),
        .o_s1_col       (s1_col),
        .o_s1_row       (s1_row)
    );

    // most recent source row
    scl2x_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_prev_line (
        .i_clk     (i_clk),
        .i_wr_en   (load && !flush),
        .i_wr_addr (col),
        .i_wr_data (i_pixel),
        .i_rd_en   (load),
        .i_rd_addr (prev_rd_addr),
        .o_rd_data (prev_rd_data)
    );

    // row before that, written back with the centre once the stage moves on
    scl2x_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_older_line (
        .i_clk     (i_clk),
        .i_wr_en   (s1_valid && s1_advance),
        .i_wr_addr (s1_col),
        .i_wr_data (centre),
        .i_rd_en   (load),
        .i_rd_addr (col),
        .o_rd_data (older_rd_data)
    );

    // expansion rule and result register
    scl2x_kernel #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_kernel (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_flush         (flush),
        .i_pixel         (i_pixel),
        .i_prev_rd_data  (prev_rd_data),
        .i_older_rd_data (older_rd_data),
        .i_s1_valid      (s1_valid),
        .i_s1_ctrl       (s1_ctrl),
        .i_s1_col        (s1_col),
        .i_s1_row        (s1_row),
        .o_s1_advance    (s1_advance),
        .o_centre        (centre),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_top_left      (o_top_left),
        .o_top_right     (o_top_right),
        .o_bottom_left   (o_bottom_left),
        .o_bottom_right  (o_bottom_right),
        .o_src_col       (o_src_col),
        .o_src_row       (o_src_row)
    );

endmodule

@@ sim/scale2x_pixel_upscaler_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scale2x_pixel_upscaler_test
// Self-checking bench for the streaming 2x pixel-art upscaler. Source pixels
// and flush transfers go in through a valid/ready channel with random gaps.
// Output blocks come back under random back-pressure. Each accepted transfer
// runs through a local line-store predictor. Every output block is compared
// field by field with the oldest predicted block.
// ----------------------------------------------------------------------------
module scale2x_pixel_upscaler_test;
    import scl2x_pkg::*;

    localparam int PIX_W        = PIXEL_BITS_DEF;
    localparam int LINE_DEPTH   = MAX_WIDTH_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int SETTLE_CYCLES = 4;

    typedef logic [PIX_W-1:0] pix_t;

    // one 2x2 output block with the coordinates of its centre
    typedef struct packed {
        pix_t                    tl;
        pix_t                    tr;
        pix_t                    bl;
        pix_t                    br;
        logic [COL_OUT_BITS-1:0] col;
        logic [ROW_BITS-1:0]     row;
    } out_block_t;

    // dut ports
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_wr_en   = 1'b0;
    logic [CFG_BITS-1:0]     i_cfg_wr_data = '0;
    logic                    i_valid       = 1'b0;
    logic                    o_ready;
    t_action                 i_action      = ACT_PIXEL;
    pix_t                    i_pixel       = '0;
    logic                    o_valid;
    logic                    i_ready       = 1'b0;
    pix_t                    o_top_left;
    pix_t                    o_top_right;
    pix_t                    o_bottom_left;
    pix_t                    o_bottom_right;
    logic [COL_OUT_BITS-1:0] o_src_col;
    logic [ROW_BITS-1:0]     o_src_row;

    // predictor state
    logic [CFG_BITS-1:0] width_cfg = CFG_BITS'(CFG_WIDTH_RESET);
    pix_t                above_line [LINE_DEPTH];
    pix_t                two_up_line [LINE_DEPTH];
    pix_t                left_pix;
    int unsigned         col_pos;
    int unsigned         row_pos;
    out_block_t          block_q [$];

    // bench bookkeeping
    pix_t        palette [4];
    int unsigned err_count   = 0;
    int unsigned item_count  = 0;
    int          stall_left  = 0;
    int unsigned idle_cycles = 0;
    bit          idle_en     = 1'b1;

    always #5 i_clk = ~i_clk;

    scale2x_pixel_upscaler u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_top_left     (o_top_left),
        .o_top_right    (o_top_right),
        .o_bottom_left  (o_bottom_left),
        .o_bottom_right (o_bottom_right),
        .o_src_col      (o_src_col),
        .o_src_row      (o_src_row)
    );

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!idle_en) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // frame width after clamping to what the line stores hold
    function automatic int unsigned active_width();
        int unsigned w;
        w = width_cfg;
        if (w < MIN_WIDTH) w = MIN_WIDTH;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        return w;
    endfunction

    function automatic pix_t random_pixel();
        if ($urandom_range(0, 99) < 20) return pix_t'($urandom);
        return palette[$urandom_range(0, 3)];
    endfunction

    task automatic new_palette();
        foreach (palette[i]) begin
            case ($urandom_range(0, 5))
                0: palette[i] = '0;
                1: palette[i] = '1;
                default: palette[i] = pix_t'($urandom);
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= 100)
            $display("%t: %s mismatch, got %h, expected %h", $realtime, what, got, want);
    endtask

    // update the line stores for one accepted transfer, queue the block it yields
    task automatic scale_transfer(input t_action act, input pix_t px);
        int unsigned w;
        int unsigned x;
        pix_t        e, b, d, f, h;
        out_block_t  blk;
        bit          flush;
        flush = (act == ACT_FLUSH);
        w = active_width();
        x = col_pos;
        // flush with no row stored is dropped without any change
        if (flush && row_pos == 0) return;
        e = above_line[x];
        if (row_pos > 0) begin
            b = (row_pos >= 2) ? two_up_line[x] : e;
            d = (x > 0) ? left_pix : e;
            f = (x + 1 < w) ? above_line[x + 1] : e;
            h = flush ? e : px;
            blk.tl = e;
            blk.tr = e;
            blk.bl = e;
            blk.br = e;
            if (b != h && d != f) begin
                if (d == b) blk.tl = d;
                if (b == f) blk.tr = f;
                if (d == h) blk.bl = d;
                if (h == f) blk.br = f;
            end
            blk.col = x[COL_OUT_BITS-1:0];
            blk.row = ROW_BITS'(row_pos - 1);
            block_q.push_back(blk);
        end
        two_up_line[x] = e;
        left_pix = e;
        if (!flush) above_line[x] = px;
        // column and row advance; a flush that ends its row starts a new frame
        if (x + 1 >= w) begin
            col_pos = 0;
            if (flush) row_pos = 0;
            else if (row_pos < ROW_MAX) row_pos++;
        end else begin
            col_pos++;
        end
    endtask

    // one input transfer, after a random gap
    task automatic send_item(input t_action act, input pix_t px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_pixel  <= px;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        if (!(act == ACT_FLUSH && row_pos == 0)) item_count++;
        scale_transfer(act, px);
    endtask

    // wait until every predicted block is out and the pipeline has drained
    task automatic settle_block();
        i_valid <= 1'b0;
        while (block_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_width(input logic [CFG_BITS-1:0] value);
        settle_block();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        width_cfg = value;
    endtask

    // flush transfers until the bottom row is out and the frame closes
    task automatic finish_frame();
        while (row_pos != 0) send_item(ACT_FLUSH, pix_t'($urandom));
    endtask

    // one frame slot: mostly pixels, some flushes inside rows, a few dropped flushes
    task automatic send_frame_item();
        if (row_pos == 0 && $urandom_range(0, 99) < 3)
            send_item(ACT_FLUSH, pix_t'($urandom));
        if (row_pos > 0 && $urandom_range(0, 99) < 8)
            send_item(ACT_FLUSH, random_pixel());
        else
            send_item(ACT_PIXEL, random_pixel());
    endtask

    // reset width fills the whole line store, then the row is cut short
    task automatic test_reset_width();
        for (int i = 0; i < LINE_DEPTH; i++) send_item(ACT_PIXEL, pix_t'($urandom));
        send_item(ACT_PIXEL, pix_t'($urandom));
        send_item(ACT_FLUSH, pix_t'($urandom));
        send_item(ACT_PIXEL, pix_t'($urandom));
        // column 3 lies beyond the new width and closes the row
        write_frame_width(CFG_BITS'(1));
        finish_frame();
    endtask

    // narrowest frame with all-zero and all-one pixels
    task automatic test_extremes();
        write_frame_width('0);
        send_item(ACT_FLUSH, '1);
        send_item(ACT_PIXEL, '0);
        send_item(ACT_PIXEL, '1);
        send_item(ACT_PIXEL, '1);
        send_item(ACT_PIXEL, '0);
        send_item(ACT_PIXEL, '0);
        send_item(ACT_PIXEL, '1);
        send_item(ACT_FLUSH, '0);
        send_item(ACT_FLUSH, '1);
    endtask

    // 3x3 pattern where the centre takes corners from its neighbors
    task automatic test_scale2x_rule();
        pix_t grid [9] = '{16'h0007, 16'h0002, 16'h0007,
                           16'h0002, 16'h0005, 16'h0003,
                           16'h0007, 16'h0003, 16'h0007};
        write_frame_width(CFG_BITS'(3));
        foreach (grid[i]) send_item(ACT_PIXEL, grid[i]);
        finish_frame();
    endtask

    // random frames, mostly narrow, every so often one at or near full width
    task automatic test_random_frames();
        int unsigned w;
        int unsigned rows;
        int unsigned cut;
        int          frame_no;
        bit          wide;
        frame_no = 0;
        while (item_count < RANDOM_ITEMS) begin
            wide = (frame_no % 7 == 1);
            idle_en = ($urandom_range(0, 4) != 0);
            new_palette();
            if (wide) begin
                if (frame_no == 1) begin
                    write_frame_width('1);
                end else begin
                    case ($urandom_range(0, 3))
                        0: write_frame_width(CFG_BITS'(255));
                        1: write_frame_width(CFG_BITS'(256));
                        2: write_frame_width(CFG_BITS'(257));
                        default: write_frame_width('1);
                    endcase
                end
                rows = 1;
            end else begin
                write_frame_width(CFG_BITS'($urandom_range(0, 17)));
                rows = $urandom_range(1, 6);
            end
            w = active_width();
            for (int s = 0; s < rows * w; s++) send_frame_item();
            if (wide && $urandom_range(0, 1) == 1) begin
                // cut the next row short by narrowing it mid-row
                cut = $urandom_range(2, 20);
                for (int s = 0; s < cut; s++) send_frame_item();
                write_frame_width(CFG_BITS'($urandom_range(0, col_pos)));
            end else if (row_pos > 0 && $urandom_range(0, 2) == 0) begin
                // partial last row, the flushes start mid-row
                cut = $urandom_range(1, w - 1);
                for (int s = 0; s < cut; s++) send_frame_item();
            end
            finish_frame();
            frame_no++;
        end
        idle_en = 1'b1;
    endtask

    // output transfers: compare against the oldest predicted block, drive back-pressure
    always @(posedge i_clk) begin
        out_block_t want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (block_q.size() == 0) begin
                report_mismatch("unexpected block row/col", 32'({o_src_row, o_src_col}),
                                '0);
            end else begin
                want = block_q.pop_front();
                if (o_top_left !== want.tl)
                    report_mismatch("top_left", 32'(o_top_left), 32'(want.tl));
                if (o_top_right !== want.tr)
                    report_mismatch("top_right", 32'(o_top_right), 32'(want.tr));
                if (o_bottom_left !== want.bl)
                    report_mismatch("bottom_left", 32'(o_bottom_left), 32'(want.bl));
                if (o_bottom_right !== want.br)
                    report_mismatch("bottom_right", 32'(o_bottom_right), 32'(want.br));
                if (o_src_col !== want.col)
                    report_mismatch("src_col", 32'(o_src_col), 32'(want.col));
                if (o_src_row !== want.row)
                    report_mismatch("src_row", 32'(o_src_row), 32'(want.row));
            end
        end
        if (!idle_en) begin
            stall_left = 0;
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            i_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("scale2x_pixel_upscaler verification failed");
            $finish;
        end
    end

    initial begin
        foreach (above_line[i]) begin
            above_line[i]  = '0;
            two_up_line[i] = '0;
        end
        left_pix = '0;
        col_pos  = 0;
        row_pos  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_width();
        test_extremes();
        test_scale2x_rule();
        test_random_frames();

        settle_block();
        if (err_count == 0) begin
            $display("scale2x_pixel_upscaler verification clean");
        end else begin
            $display("scale2x_pixel_upscaler verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/scl2x_pkg.sv
rtl/core/scl2x_ram.sv
rtl/core/scl2x_ctrl.sv
rtl/core/scl2x_kernel.sv
rtl/core/scale2x_pixel_upscaler.sv
sim/scale2x_pixel_upscaler_test.sv
